// ===== hdl/lzwm_pkg.sv =====
`default_nettype none
package lzwm_pkg;

    localparam int WINDOW_DEF = 256;
    localparam int BYTE_W     = 8;
    localparam int DIST_W     = 9;
    localparam int LEN_W      = 9;

    // Control that the top level broadcasts to every cell of the window.
    typedef struct packed {
        logic adv;      // a byte transfer happens in this cycle
        logic keep_tk;  // the token goes on: shift the token-span marks
        logic clear;    // end of stream: drop the whole window
        logic m_zero;   // no match is pending, so a new token starts here
    } lzwm_ctl_t;

    // Token fields that travel beside the farthest-distance search.
    typedef struct packed {
        logic              literal;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] next_byte;
        logic              has_next;
    } lzwm_tag_t;

    // One finished triple.
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] next_byte;
        logic              has_next;
    } lzwm_res_t;

endpackage
`default_nettype wire

// ===== hdl/lzwm_cell.sv =====
`default_nettype none
// One window position: holds the byte at a fixed backward distance and
// passes it to the next cell on every transfer.
module lzwm_cell (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire lzwm_pkg::lzwm_ctl_t       ctl,
    input  wire [lzwm_pkg::BYTE_W-1:0]     cur_byte,
    input  wire [lzwm_pkg::BYTE_W-1:0]     byte_in,
    input  wire                            val_in,
    input  wire                            tk_in,
    output logic [lzwm_pkg::BYTE_W-1:0]    byte_out,
    output logic                           val_out,
    output logic                           tk_out,
    output logic                           was,
    output logic                           ext
);

    logic [lzwm_pkg::BYTE_W-1:0] byte_reg;
    logic                        val_reg;
    logic                        tk_reg;
    logic                        alive_reg;

    // A candidate that lies inside the current token may not extend.
    always_comb
    begin
        was      = ctl.m_zero ? val_reg : alive_reg;
        ext      = was & ~tk_reg & (byte_reg == cur_byte);
        byte_out = byte_reg;
        val_out  = val_reg;
        tk_out   = tk_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            byte_reg <= byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg   <= 1'b0;
            tk_reg    <= 1'b0;
            alive_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            val_reg   <= ctl.clear ? 1'b0 : val_in;
            tk_reg    <= ctl.keep_tk ? tk_in : 1'b0;
            alive_reg <= ctl.clear ? 1'b0 : ext;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lzwm_far_tree.sv =====
`default_nettype none
// Registered binary tree that finds the largest set position (1-based) of a
// candidate vector, one level per cycle; the token fields ride alongside.
module lzwm_far_tree #(
    parameter int WINDOW = lzwm_pkg::WINDOW_DEF,
    parameter int IW     = $clog2(WINDOW + 1),
    parameter int LV     = ($clog2(WINDOW) < 1) ? 1 : $clog2(WINDOW)
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        valid_in,
    input  wire [WINDOW-1:0]           vec,
    input  wire lzwm_pkg::lzwm_tag_t   tag_in,
    output logic                       valid_out,
    output logic [IW-1:0]              far,
    output lzwm_pkg::lzwm_tag_t        tag_out
);

    localparam int NL = 2 ** LV;

    logic [NL-1:0]          leaf_v;
    logic [IW-1:0]          leaf_i [NL];
    logic [NL-1:0]          stage_v [LV];
    logic [IW-1:0]          stage_i [LV][NL];
    logic [NL-1:0]          node_v_reg [LV];
    logic [IW-1:0]          node_i_reg [LV][NL];
    lzwm_pkg::lzwm_tag_t    tag_reg [LV];
    logic [LV-1:0]          vld_reg;

    for (genvar g = 0; g < NL; g++)
    begin : g_leaf
        if (g < WINDOW)
        begin : g_used
            assign leaf_v[g] = vec[g];
        end
        else
        begin : g_pad
            assign leaf_v[g] = 1'b0;
        end
        assign leaf_i[g] = IW'(g + 1);
    end

    // The first level reads the leaves, every later level the one before it.
    always_comb
    begin
        for (int j = 0; j < NL; j++)
        begin
            stage_v[0][j] = leaf_v[j];
            stage_i[0][j] = leaf_i[j];
        end
        for (int lv = 1; lv < LV; lv++)
        begin
            for (int j = 0; j < NL; j++)
            begin
                stage_v[lv][j] = node_v_reg[lv-1][j];
                stage_i[lv][j] = node_i_reg[lv-1][j];
            end
        end
    end

    // The right child holds the larger distances, so it wins when set.
    always_ff @(posedge clk)
    begin
        for (int lv = 0; lv < LV; lv++)
        begin
            for (int j = 0; j < NL / 2; j++)
            begin
                node_v_reg[lv][j] <= stage_v[lv][2*j] | stage_v[lv][2*j+1];
                node_i_reg[lv][j] <= stage_v[lv][2*j+1] ? stage_i[lv][2*j+1]
                                                        : stage_i[lv][2*j];
            end
            for (int j = NL / 2; j < NL; j++)
            begin
                node_v_reg[lv][j] <= 1'b0;
                node_i_reg[lv][j] <= '0;
            end
            tag_reg[lv] <= (lv == 0) ? tag_in : tag_reg[(lv == 0) ? 0 : lv - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= LV'({vld_reg, valid_in});
        end
    end

    assign valid_out = vld_reg[LV-1];
    assign far       = node_i_reg[LV-1][0];
    assign tag_out   = tag_reg[LV-1];

endmodule
`default_nettype wire

// ===== hdl/lzwm_out_fifo.sv =====
`default_nettype none
// Result queue. Space is reserved when a byte that ends a token is taken in,
// so results still inside the search tree always find a free slot.
module lzwm_out_fifo #(
    parameter int DEPTH = 10
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        reserve,
    output logic                       can_take,
    input  wire                        push,
    input  wire lzwm_pkg::lzwm_res_t   push_data,
    output logic                       out_valid,
    input  wire                        out_ready,
    output lzwm_pkg::lzwm_res_t        out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lzwm_pkg::lzwm_res_t mem [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       owed_reg;
    logic                pop;

    assign pop       = out_valid & out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign can_take  = (owed_reg < CW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            owed_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
            owed_reg  <= owed_reg + CW'(reserve) - CW'(pop);
        end
    end

    a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg <= CW'(DEPTH))
        else $error("result reservations exceed the queue depth");

    a_count_le_owed: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= owed_reg)
        else $error("queued results exceed reservations");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CW'(DEPTH)) || pop)
        else $error("result pushed into a full queue");

endmodule
`default_nettype wire

// ===== hdl/lz77_window_match_encoder_core.sv =====
`default_nettype none
// LZ77 triple encoder with greedy longest-match search over a window of
// WINDOW earlier bytes.
//
// Input channel (in_valid/in_ready): one stream byte per transfer, with
// last_byte set on the final byte of a stream. Output channel
// (out_valid/out_ready): one triple (distance, length, next_byte, has_next)
// per transfer, emitted when a byte ends a token or the stream ends.
//
// Throughput: one byte per cycle while the consumer keeps up. Every window
// position is a cell of a shift chain and all cells compare in the same
// cycle. Each result passes through the registered tree that finds the
// farthest matching distance, then through the result queue. Here LV =
// clog2(WINDOW) (8 for a window of 256).
//
// When the consumer stalls, results collect in a queue of LV+2 entries;
// in_ready drops only when that many results are owed and not yet taken.
// Reset (and the transfer of a final byte) empties the window and ends any
// pending match; no clearing pass is needed.
module lz77_window_match_encoder_core #(
    parameter int WINDOW = lzwm_pkg::WINDOW_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire [lzwm_pkg::BYTE_W-1:0]      data_byte,
    input  wire                             last_byte,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [lzwm_pkg::DIST_W-1:0]     distance,
    output logic [lzwm_pkg::LEN_W-1:0]      length,
    output logic [lzwm_pkg::BYTE_W-1:0]     next_byte,
    output logic                            has_next
);

    localparam int MW    = $clog2(WINDOW + 1);
    localparam int LV    = ($clog2(WINDOW) < 1) ? 1 : $clog2(WINDOW);
    localparam int DEPTH = LV + 2;

    logic [MW-1:0]               m_reg;
    logic [MW-1:0]               m_next;
    logic                        in_xfer;
    logic                        any_ext;
    logic                        emit;
    lzwm_pkg::lzwm_ctl_t         ctl;
    lzwm_pkg::lzwm_tag_t         tag;
    lzwm_pkg::lzwm_tag_t         tag_far;
    lzwm_pkg::lzwm_res_t         res;
    lzwm_pkg::lzwm_res_t         res_out;
    logic                        far_valid;
    logic [MW-1:0]               far;
    logic [lzwm_pkg::BYTE_W-1:0] cell_byte [WINDOW];
    logic [WINDOW-1:0]           cell_val;
    logic [WINDOW-1:0]           cell_tk;
    logic [WINDOW-1:0]           was_v;
    logic [WINDOW-1:0]           ext_v;
    logic [WINDOW-1:0]           far_vec;

    assign in_xfer = in_valid & in_ready;

    // A token goes on while at least one candidate extends with the new byte.
    assign any_ext = |ext_v;
    assign emit    = ~any_ext | last_byte;

    always_comb
    begin
        ctl.adv     = in_xfer;
        ctl.keep_tk = any_ext & ~last_byte;
        ctl.clear   = last_byte;
        ctl.m_zero  = (m_reg == '0);
    end

    // Cell d (index d-1) holds the byte at backward distance d. The new
    // byte enters the first cell; it is always valid and, when the token
    // goes on, part of the token.
    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            lzwm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .cur_byte (data_byte),
                .byte_in  (data_byte),
                .val_in   (1'b1),
                .tk_in    (1'b1),
                .byte_out (cell_byte[g]),
                .val_out  (cell_val[g]),
                .tk_out   (cell_tk[g]),
                .was      (was_v[g]),
                .ext      (ext_v[g])
            );
        end
        else
        begin : g_body
            lzwm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .cur_byte (data_byte),
                .byte_in  (cell_byte[g-1]),
                .val_in   (cell_val[g-1]),
                .tk_in    (cell_tk[g-1]),
                .byte_out (cell_byte[g]),
                .val_out  (cell_val[g]),
                .tk_out   (cell_tk[g]),
                .was      (was_v[g]),
                .ext      (ext_v[g])
            );
        end
    end

    // The reported distance is the farthest candidate of the live set: the
    // extended set when the final byte still extends, otherwise the set
    // that was alive before this byte. A literal reports distance zero.
    always_comb
    begin
        far_vec       = any_ext ? ext_v : was_v;
        tag.literal   = ~any_ext & (m_reg == '0);
        tag.length    = any_ext ? lzwm_pkg::LEN_W'(m_reg + 1'b1)
                                : lzwm_pkg::LEN_W'(m_reg);
        tag.next_byte = any_ext ? '0 : data_byte;
        tag.has_next  = ~any_ext;
    end

    always_comb
    begin
        if (!in_xfer || last_byte)
        begin
            m_next = in_xfer ? '0 : m_reg;
        end
        else if (any_ext)
        begin
            m_next = m_reg + 1'b1;
        end
        else
        begin
            m_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
        end
        else
        begin
            m_reg <= m_next;
        end
    end

    lzwm_far_tree #(
        .WINDOW (WINDOW),
        .IW     (MW),
        .LV     (LV)
    ) u_far_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_xfer & emit),
        .vec       (far_vec),
        .tag_in    (tag),
        .valid_out (far_valid),
        .far       (far),
        .tag_out   (tag_far)
    );

    always_comb
    begin
        res.distance  = tag_far.literal ? '0 : lzwm_pkg::DIST_W'(far);
        res.length    = tag_far.length;
        res.next_byte = tag_far.next_byte;
        res.has_next  = tag_far.has_next;
    end

    lzwm_out_fifo #(
        .DEPTH (DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .reserve   (in_xfer & emit),
        .can_take  (in_ready),
        .push      (far_valid),
        .push_data (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res_out)
    );

    assign distance  = res_out.distance;
    assign length    = res_out.length;
    assign next_byte = res_out.next_byte;
    assign has_next  = res_out.has_next;

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_reg <= MW'(WINDOW))
        else $error("match length ran past the window");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && last_byte |=> m_reg == '0)
        else $error("match still pending after the final byte");

    a_break_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !any_ext |=> m_reg == '0)
        else $error("token did not restart after a mismatch");

    a_pending_has_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (m_reg != '0) |-> (|was_v))
        else $error("match pending with no live candidate");

endmodule
`default_nettype wire

// ===== tb/lz77_window_match_encoder_core_tb.sv =====
`default_nettype none
module lz77_window_match_encoder_core_tb;

    localparam int WIN          = lzwm_pkg::WINDOW_DEF;
    localparam int HDEPTH       = 2 * WIN;
    // Depth of the farthest-distance search tree in the block.
    localparam int LV           = $clog2(WIN);
    // Worst quiet stretch is the long receiver hold-off.
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 10 * HOLD_CYCLES;
    localparam int MAX_REPORTS  = 10;

    typedef logic [lzwm_pkg::BYTE_W-1:0] byte_q_t[$];

    // Flavors of stream content for the random part.
    typedef enum int {
        SRC_NOISE,
        SRC_FEW,
        SRC_PERIODIC,
        SRC_RUNS
    } src_kind_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [lzwm_pkg::BYTE_W-1:0]   data_byte = '0;
    logic                          last_byte = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [lzwm_pkg::DIST_W-1:0]   distance;
    logic [lzwm_pkg::LEN_W-1:0]    length;
    logic [lzwm_pkg::BYTE_W-1:0]   next_byte;
    logic                          has_next;

    // Traffic shaping, changed by the test tasks between transfers.
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    int items_sent = 0;
    int err_count = 0;
    int quiet_cycles = 0;

    // Encoder state mirrored for prediction.
    logic [lzwm_pkg::BYTE_W-1:0] hist_mem [HDEPTH];
    int                          hist_fill;
    int                          hist_wp;
    int                          tok_len;
    logic [WIN-1:0]              live_dist;

    lzwm_pkg::lzwm_res_t triple_q[$];
    lzwm_pkg::lzwm_res_t head_triple;

    lz77_window_match_encoder_core #(
        .WINDOW(WIN)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .distance(distance),
        .length(length),
        .next_byte(next_byte),
        .has_next(has_next)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic clear_window();
        foreach (hist_mem[i])
        begin
            hist_mem[i] = '0;
        end
        hist_fill = 0;
        hist_wp   = 0;
        tok_len   = 0;
        live_dist = '0;
    endtask

    // Advances the mirrored encoder by one byte and queues the triple that
    // the byte finishes, if any.
    task automatic encode_byte(input logic [lzwm_pkg::BYTE_W-1:0] b, input logic fin);
        int                  m;
        int                  old_far;
        int                  new_far;
        int                  idx;
        logic                hit;
        logic                was;
        logic [WIN-1:0]      nxt;
        lzwm_pkg::lzwm_res_t r;
        m       = tok_len;
        old_far = 0;
        new_far = 0;
        hit     = 1'b0;
        nxt     = '0;
        for (int d = 1; d <= WIN; d++)
        begin
            // A fresh token may start at any valid window byte; a running
            // token keeps only the distances that still match.
            was = (m == 0) ? (d <= hist_fill) : live_dist[d-1];
            if (was)
            begin
                old_far = d;
                if (m < d)
                begin
                    idx = (hist_wp + HDEPTH - d) % HDEPTH;
                    if (hist_mem[idx] == b)
                    begin
                        nxt[d-1] = 1'b1;
                        hit      = 1'b1;
                        new_far  = d;
                    end
                end
            end
        end
        hist_mem[hist_wp] = b;
        hist_wp = (hist_wp + 1) % HDEPTH;

        if (hit)
        begin
            live_dist = nxt;
            tok_len   = m + 1;
            if (fin)
            begin
                // The stream ends inside a match: no following byte.
                r.distance  = lzwm_pkg::DIST_W'(new_far);
                r.length    = lzwm_pkg::LEN_W'(tok_len);
                r.next_byte = '0;
                r.has_next  = 1'b0;
                triple_q = {triple_q, r};
                clear_window();
            end
        end
        else
        begin
            r.distance  = (m == 0) ? '0 : lzwm_pkg::DIST_W'(old_far);
            r.length    = lzwm_pkg::LEN_W'(m);
            r.next_byte = b;
            r.has_next  = 1'b1;
            triple_q = {triple_q, r};
            hist_fill = hist_fill + m + 1;
            if (hist_fill > WIN)
            begin
                hist_fill = WIN;
            end
            tok_len   = 0;
            live_dist = '0;
            if (fin)
            begin
                clear_window();
            end
        end
    endtask

    task automatic report_error(input string msg);
        if (err_count < MAX_REPORTS)
        begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
        err_count++;
    endtask

    // Offers one byte, with a random idle gap ahead of it, and predicts its
    // effect once the transfer has happened.
    task automatic send_byte(input logic [lzwm_pkg::BYTE_W-1:0] b, input logic fin);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        encode_byte(b, fin);
        items_sent++;
    endtask

    task automatic send_stream(input byte_q_t s);
        foreach (s[i])
        begin
            send_byte(s[i], i == s.size() - 1);
        end
    endtask

    task automatic make_stream(output byte_q_t s);
        src_kind_t                   kind;
        int                          len;
        int                          period;
        logic [lzwm_pkg::BYTE_W-1:0] alpha [3];
        logic [lzwm_pkg::BYTE_W-1:0] pat [$];
        logic [lzwm_pkg::BYTE_W-1:0] cur;
        s = {};
        pat = {};
        kind = src_kind_t'($urandom_range(0, 3));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
        foreach (alpha[i])
        begin
            alpha[i] = lzwm_pkg::BYTE_W'($urandom_range(0, 255));
        end
        period = $urandom_range(1, 48);
        for (int i = 0; i < period; i++)
        begin
            pat = {pat, lzwm_pkg::BYTE_W'($urandom_range(0, 255))};
        end
        cur = lzwm_pkg::BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                SRC_NOISE:    s = {s, lzwm_pkg::BYTE_W'($urandom_range(0, 255))};
                SRC_FEW:      s = {s, alpha[$urandom_range(0, 2)]};
                SRC_PERIODIC:
                begin
                    // Mostly exact repeats, with a rare corrupted byte that
                    // breaks a long match in the middle.
                    if ($urandom_range(0, 15) == 0)
                    begin
                        s = {s, lzwm_pkg::BYTE_W'($urandom_range(0, 255))};
                    end
                    else
                    begin
                        s = {s, pat[i % period]};
                    end
                end
                default:
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        cur = lzwm_pkg::BYTE_W'($urandom_range(0, 255));
                    end
                    s = {s, cur};
                end
            endcase
        end
    endtask

    // Short hand-built streams: extreme bytes, literals, a match cut by the
    // end of the stream, a match ended by the final byte, and a tie between
    // two distances of the same length.
    task automatic test_special_cases();
        byte_q_t s;
        idle_pct  = 0;
        stall_pct = 0;
        s = {8'h00};
        send_stream(s);
        s = {8'hFF};
        send_stream(s);
        s = {8'h41, 8'h42, 8'h41, 8'h42};
        send_stream(s);
        s = {8'h41, 8'h41, 8'h41};
        send_stream(s);
        s = {8'h61, 8'h7A, 8'h61, 8'h62, 8'h61, 8'h63};
        send_stream(s);
        s = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        send_stream(s);
    endtask

    // A permutation of all byte values fills the window with literals only;
    // repeating it gives one match that reaches the full window length at
    // the full window distance.
    task automatic test_window_limit();
        byte_q_t                     s;
        logic [lzwm_pkg::BYTE_W-1:0] perm [WIN];
        logic [lzwm_pkg::BYTE_W-1:0] tmp;
        int                          j;
        idle_pct  = 18;
        stall_pct = 18;
        for (int i = 0; i < WIN; i++)
        begin
            perm[i] = lzwm_pkg::BYTE_W'(i);
        end
        for (int i = WIN - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        s = {};
        for (int i = 0; i < 2 * WIN; i++)
        begin
            s = {s, perm[i % WIN]};
        end
        s = {s, lzwm_pkg::BYTE_W'($urandom_range(0, 255))};
        send_stream(s);
    endtask

    task automatic test_random_streams(input int in_idle, input int out_stall, input int n);
        byte_q_t s;
        int      start;
        idle_pct  = in_idle;
        stall_pct = out_stall;
        start = items_sent;
        while (items_sent - start < n)
        begin
            make_stream(s);
            send_stream(s);
        end
    endtask

    // The receiver stops for a long stretch while bytes keep coming, so the
    // result queue in the block fills and in_ready must drop.
    task automatic test_backpressure();
        byte_q_t s;
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        s = {};
        for (int i = 0; i < 60; i++)
        begin
            s = {s, lzwm_pkg::BYTE_W'($urandom_range(0, 255))};
        end
        send_stream(s);
    endtask

    // Receiver: random stalls, or a solid hold-off while one is pending.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Each output transfer is checked against the oldest predicted triple.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (triple_q.size() == 0)
            begin
                report_error($sformatf("unexpected triple d=%0d l=%0d nb=%02h hn=%0b",
                                       distance, length, next_byte, has_next));
            end
            else
            begin
                head_triple = triple_q.pop_front();
                if (head_triple.distance !== distance || head_triple.length !== length ||
                    head_triple.next_byte !== next_byte ||
                    head_triple.has_next !== has_next)
                begin
                    report_error($sformatf(
                        "triple exp d=%0d l=%0d nb=%02h hn=%0b got d=%0d l=%0d nb=%02h hn=%0b",
                        head_triple.distance, head_triple.length, head_triple.next_byte,
                        head_triple.has_next, distance, length, next_byte, has_next));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] ERROR: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        clear_window();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_special_cases();
        test_random_streams(0, 0, 130);
        test_window_limit();
        test_random_streams(56, 0, 130);
        test_random_streams(0, 56, 130);
        test_backpressure();
        test_random_streams(18, 18, 130);

        @(negedge clk);
        in_valid <= 1'b0;
        while (triple_q.size() != 0)
        begin
            @(posedge clk);
        end
        // Give any stray result time to surface through the search tree.
        repeat (4 * LV + 8) @(posedge clk);

        if (err_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== lz77_window_match_encoder_core.f =====
hdl/lzwm_pkg.sv
hdl/lzwm_cell.sv
hdl/lzwm_far_tree.sv
hdl/lzwm_out_fifo.sv
hdl/lz77_window_match_encoder_core.sv
tb/lz77_window_match_encoder_core_tb.sv
